>>> hw/rtl/lmin3_pkg.sv
// Shared constants of the 3x3 local minimum detector: config layout and window geometry.
`default_nettype none

package lmin3_pkg;

  // config port layout
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int ROW_COUNT_W = 13;
  localparam int COL_COUNT_W = 11;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;

  // candidate centres per item, in raster order: window row and column of each
  localparam int NUM_CAND = 4;
  localparam int WIN_ROW [NUM_CAND] = '{1, 1, 2, 2};
  localparam int WIN_COL [NUM_CAND] = '{1, 2, 1, 2};

endpackage

`default_nettype wire

>>> hw/rtl/local_minimum_3x3_detector.sv
// Top level of the streaming 3x3 strict local minimum detector.
`default_nettype none

// Streaming 3x3 strict local minimum detector. A matrix of row_count x col_count
// signed values enters in raster order, one item per cycle; for every position a
// result carries the value, its row and column and a flag that is set when every
// neighbour inside the matrix is strictly greater (neighbours beyond the border
// are ignored). A verdict leaves as soon as its last neighbour has arrived, so a
// result lags its position by one row and one column; an item in the last column
// or the last row releases up to two verdicts and the final position up to four.
// An accepted item passes stage 1 and stage 2 before its results reach the result register. An
// item that causes at most one result is accepted every cycle while the output
// does not stall; one causing several results stalls the input until the single
// result register takes the last of them. The two previous
// lines live in one line store of MAX_COLS words of 2*DATA_WIDTH bits, read when
// an item is accepted and written back when it leaves the window stage; a read of
// the column being written in the same cycle takes the written word. The store
// needs no clearing pass: stale words only ever stand for neighbours outside the
// matrix. A config write (index 0 rows, 1 columns) restarts the frame; a zero
// size acts as one and a size above the maximum saturates to it.
module local_minimum_3x3_detector #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 4096,
  parameter int DATA_WIDTH = 32,
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // config write channel
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire        [lmin3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire        [lmin3_pkg::CFG_DATA_W-1:0] cfg_data,
  // item input
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire signed [DATA_WIDTH-1:0]           in_pixel_value,
  // results
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [DATA_WIDTH-1:0]          out_center_value,
  output logic       [ROW_W-1:0]                out_row_index,
  output logic       [COL_W-1:0]                out_col_index,
  output logic                                  out_is_minimum,
  output logic                                  out_last_of_run,
  output logic                                  out_frame_done
);

  import lmin3_pkg::*;

  localparam int MEM_W = 2 * DATA_WIDTH;

  // frame geometry, held as last index
  logic [ROW_W-1:0] last_row_r, last_row_nxt;
  logic [COL_W-1:0] last_col_r, last_col_nxt;
  logic [ROW_W-1:0] row_cnt_r;
  logic [COL_W-1:0] col_cnt_r;

  // stage 1: accepted item plus its line store word
  logic                          s1_valid_r;
  logic signed [DATA_WIDTH-1:0]  s1_value_r;
  logic [ROW_W-1:0]              s1_row_r;
  logic [COL_W-1:0]              s1_col_r;
  logic [MEM_W-1:0]              rd_r;
  logic [MEM_W-1:0]              wr_data;

  // line store: upper half two rows above, lower half one row above
  logic [MEM_W-1:0] line_mem [MAX_COLS];

  // previous two window columns; the newest comes from stage 1
  logic signed [DATA_WIDTH-1:0] win_r [3][2];
  logic signed [DATA_WIDTH-1:0] win   [3][3];

  // candidate verdicts of the item in stage 1
  logic [NUM_CAND-1:0]          cand_mask;
  logic [NUM_CAND-1:0]          cand_min;
  logic [NUM_CAND-1:0]          cand_done;
  logic [ROW_W-1:0]             cand_row [NUM_CAND];
  logic [COL_W-1:0]             cand_col [NUM_CAND];
  logic signed [DATA_WIDTH-1:0] cand_val [NUM_CAND];
  logic [NUM_CAND-1:0]          top_ok, bot_ok, left_ok, right_ok;

  // stage 2: verdicts waiting for the result register
  logic [NUM_CAND-1:0]          pend_r;
  logic [NUM_CAND-1:0]          rec_min_r;
  logic [NUM_CAND-1:0]          rec_done_r;
  logic [ROW_W-1:0]             rec_row_r [NUM_CAND];
  logic [COL_W-1:0]             rec_col_r [NUM_CAND];
  logic signed [DATA_WIDTH-1:0] rec_val_r [NUM_CAND];
  logic [NUM_CAND-1:0]          sel;
  logic                         sel_last;

  // result register
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] out_val_r;
  logic [ROW_W-1:0]             out_row_r;
  logic [COL_W-1:0]             out_col_r;
  logic                         out_min_r;
  logic                         out_last_r;
  logic                         out_done_r;

  // handshake glue
  logic cfg_we;
  logic in_acc;
  logic out_adv;
  logic s2_emit;
  logic s2_free;
  logic s1_adv;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s2_emit  = (pend_r != '0) && out_adv;
  assign s2_free  = (pend_r == '0) || (out_adv && sel_last);
  assign s1_adv   = s1_valid_r && s2_free;
  // stage 1 takes a new item when empty or when its item moves on
  assign in_stall = s1_valid_r && !s2_free;
  assign in_acc   = in_valid && !in_stall;

  // clamp the size registers: zero acts as one, beyond the maximum saturates
  always_comb begin
    if (cfg_data[ROW_COUNT_W-1:0] == '0) begin
      last_row_nxt = '0;
    end else if (32'(cfg_data[ROW_COUNT_W-1:0]) > MAX_ROWS) begin
      last_row_nxt = ROW_W'(MAX_ROWS - 1);
    end else begin
      last_row_nxt = ROW_W'(32'(cfg_data[ROW_COUNT_W-1:0]) - 32'd1);
    end
    if (cfg_data[COL_COUNT_W-1:0] == '0) begin
      last_col_nxt = '0;
    end else if (32'(cfg_data[COL_COUNT_W-1:0]) > MAX_COLS) begin
      last_col_nxt = COL_W'(MAX_COLS - 1);
    end else begin
      last_col_nxt = COL_W'(32'(cfg_data[COL_COUNT_W-1:0]) - 32'd1);
    end
  end

  // geometry and raster position; a config write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_row_r <= '0;
      last_col_r <= '0;
      row_cnt_r  <= '0;
      col_cnt_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_COUNT: begin
          last_row_r <= last_row_nxt;
          row_cnt_r  <= '0;
          col_cnt_r  <= '0;
        end
        CFG_COL_COUNT: begin
          last_col_r <= last_col_nxt;
          row_cnt_r  <= '0;
          col_cnt_r  <= '0;
        end
        default: begin
          // unknown register: drop the write
        end
      endcase
    end else if (in_acc) begin
      if (col_cnt_r == last_col_r) begin
        col_cnt_r <= '0;
        row_cnt_r <= (row_cnt_r == last_row_r) ? '0 : row_cnt_r + 1'b1;
      end else begin
        col_cnt_r <= col_cnt_r + 1'b1;
      end
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // stage 1 payload and line store read; forward the word written this cycle
  assign wr_data = {rd_r[DATA_WIDTH-1:0], s1_value_r};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_value_r <= in_pixel_value;
      s1_row_r   <= row_cnt_r;
      s1_col_r   <= col_cnt_r;
      if (s1_adv && (s1_col_r == col_cnt_r)) begin
        rd_r <= wr_data;
      end else begin
        rd_r <= line_mem[col_cnt_r];
      end
    end
  end

  // write back: shift the column down the two line buffers
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_col_r] <= wr_data;
    end
  end

  // window as seen by the item in stage 1
  always_comb begin
    for (int q = 0; q < 3; q++) begin
      win[q][0] = win_r[q][0];
      win[q][1] = win_r[q][1];
    end
    win[0][2] = rd_r[MEM_W-1:DATA_WIDTH];
    win[1][2] = rd_r[DATA_WIDTH-1:0];
    win[2][2] = s1_value_r;
  end

  // advance the window as the item leaves stage 1
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int q = 0; q < 3; q++) begin
        win_r[q][0] <= win[q][1];
        win_r[q][1] <= win[q][2];
      end
    end
  end

  // candidate positions, emission mask and frame edges
  always_comb begin
    for (int e = 0; e < NUM_CAND; e++) begin
      cand_row[e]  = (WIN_ROW[e] == 1) ? s1_row_r - 1'b1 : s1_row_r;
      cand_col[e]  = (WIN_COL[e] == 1) ? s1_col_r - 1'b1 : s1_col_r;
      cand_val[e]  = win[2'(WIN_ROW[e])][2'(WIN_COL[e])];
      top_ok[e]    = cand_row[e] != '0;
      bot_ok[e]    = cand_row[e] != last_row_r;
      left_ok[e]   = cand_col[e] != '0;
      right_ok[e]  = cand_col[e] != last_col_r;
      cand_done[e] = !bot_ok[e] && !right_ok[e];
    end
    cand_mask[0] = (s1_row_r != '0) && (s1_col_r != '0);
    cand_mask[1] = (s1_row_r != '0) && (s1_col_r == last_col_r);
    cand_mask[2] = (s1_row_r == last_row_r) && (s1_col_r != '0);
    cand_mask[3] = (s1_row_r == last_row_r) && (s1_col_r == last_col_r);
  end

  // strict minimum test against every in-frame neighbour held in the window
  always_comb begin
    for (int e = 0; e < NUM_CAND; e++) begin
      cand_min[e] = 1'b1;
      for (int di = -1; di <= 1; di++) begin
        for (int dj = -1; dj <= 1; dj++) begin
          if (!(di == 0 && dj == 0) &&
              (WIN_ROW[e] + di >= 0) && (WIN_ROW[e] + di <= 2) &&
              (WIN_COL[e] + dj >= 0) && (WIN_COL[e] + dj <= 2) &&
              (di != -1 || top_ok[e]) && (di != 1 || bot_ok[e]) &&
              (dj != -1 || left_ok[e]) && (dj != 1 || right_ok[e])) begin
            if (win[2'(WIN_ROW[e] + di)][2'(WIN_COL[e] + dj)] <= cand_val[e]) begin
              cand_min[e] = 1'b0;
            end
          end
        end
      end
    end
  end

  // pick the earliest pending verdict
  always_comb begin
    sel = pend_r & (~pend_r + 1'b1);
    sel_last = (pend_r & ~sel) == '0;
  end

  // stage 2 control: load a fresh set, else retire the one sent on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (s1_adv) begin
      pend_r <= cand_mask;
    end else if (s2_emit) begin
      pend_r <= pend_r & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rec_min_r  <= cand_min;
      rec_done_r <= cand_done;
      for (int e = 0; e < NUM_CAND; e++) begin
        rec_row_r[e] <= cand_row[e];
        rec_col_r[e] <= cand_col[e];
        rec_val_r[e] <= cand_val[e];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_emit) begin
      out_last_r <= sel_last;
      for (int e = 0; e < NUM_CAND; e++) begin
        if (sel[e]) begin
          out_val_r  <= rec_val_r[e];
          out_row_r  <= rec_row_r[e];
          out_col_r  <= rec_col_r[e];
          out_min_r  <= rec_min_r[e];
          out_done_r <= rec_done_r[e];
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_center_value = out_val_r;
  assign out_row_index    = out_row_r;
  assign out_col_index    = out_col_r;
  assign out_is_minimum   = out_min_r;
  assign out_last_of_run  = out_last_r;
  assign out_frame_done   = out_done_r;

`ifndef NO_ASSERTIONS
  // the final position is always the last verdict its item releases
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_done |-> out_last_of_run)
    else $error("frame_done on a result that is not last of its run");

  // a reported position lies inside the configured frame
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_row_index <= last_row_r) && (out_col_index <= last_col_r))
    else $error("result position outside the frame");

  // pending verdicts only retire while no new set is loaded
  a_pend_retire: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) && !s1_adv |=> (pend_r & ~$past(pend_r)) == '0)
    else $error("pending verdict appeared without a load");
`endif

endmodule

`default_nettype wire
